@@ rtl/thread_run_queue_defines.svh @@
// Assertion macros for the checker file of the run queue.
`ifndef THREAD_RUN_QUEUE_DEFINES_SVH
`define THREAD_RUN_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TRQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thread_run_queue: check failed");

// Next-cycle implication, disabled while reset is high.
`define TRQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thread_run_queue: check failed");

`endif

@@ rtl/trq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package trq_pkg;

  localparam int DEPTH_DEFAULT   = 16;
  localparam int ID_BITS_DEFAULT = 8;

  localparam int CMD_W      = 2;
  localparam int ID_W       = 8;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [ID_W-1:0]  thread_id;
    logic [CMD_W-1:0] cmd;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  entry_count;
    logic [ID_W-1:0]     result_id;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/trq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Command sequencer and entry memory. Entry 0 is always the head; a
// dequeue or remove closes the gap by a pipelined read-then-write sweep.
module trq_ctrl #(
  parameter int DEPTH   = trq_pkg::DEPTH_DEFAULT,
  parameter int ID_BITS = trq_pkg::ID_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire trq_pkg::req_t    req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output trq_pkg::result_t      res
);
  import trq_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [ID_BITS-1:0] mem [DEPTH];
  logic [ID_BITS-1:0] rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  logic [2:0]          state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       rd_idx, rd_idx_next;
  logic [CW-1:0]       wr_idx, wr_idx_next;
  logic                rvalid, rvalid_next;
  logic                is_deq, is_deq_next;
  logic [ID_BITS-1:0]  key, key_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [ID_W-1:0]     res_id, res_id_next;

  logic in_fire;
  logic issue;
  logic hit;

  assign req_ready = (state == S_IDLE);
  assign in_fire   = req_valid && req_ready;
  assign issue     = (rd_idx < count);
  assign hit       = is_deq || (rdata == key);

  assign res_valid       = (state == S_FIN);
  assign res.status      = res_status;
  assign res.result_id   = res_id;
  assign res.entry_count = COUNT_W'(count);

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_idx_next     = rd_idx;
    wr_idx_next     = wr_idx;
    rvalid_next     = rvalid;
    is_deq_next     = is_deq;
    key_next        = key;
    res_status_next = res_status;
    res_id_next     = res_id;
    mem_we          = 1'b0;
    mem_waddr       = wr_idx[AW-1:0];
    mem_wdata       = rdata;
    mem_re          = 1'b0;
    mem_raddr       = rd_idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_status_next = ST_OK;
          res_id_next     = '0;
          unique case (req.cmd)
            CMD_ENQUEUE: begin
              state_next = S_FIN;
              if (count == CW'(DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[AW-1:0];
                mem_wdata  = ID_BITS'(req.thread_id);
                count_next = count + 1'b1;
              end
            end
            CMD_DEQUEUE, CMD_REMOVE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_FIN;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = '0;
                rd_idx_next = CW'(1);
                wr_idx_next = '0;
                is_deq_next = (req.cmd == CMD_DEQUEUE);
                key_next    = ID_BITS'(req.thread_id);
                state_next  = S_SCAN;
              end
            end
            CMD_READ: begin
              if (CMPW'(req.position) < CMPW'(count)) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(req.position);
                state_next = S_READ;
              end else begin
                res_status_next = ST_NOT_FOUND;
                state_next      = S_FIN;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      // rdata holds the entry at wr_idx; the read of rd_idx goes out now.
      S_SCAN: begin
        if (hit) begin
          if (is_deq) begin
            res_id_next = ID_W'(rdata);
          end
          if (issue) begin
            mem_re      = 1'b1;
            rd_idx_next = rd_idx + 1'b1;
          end
          rvalid_next = issue;
          state_next  = S_SHIFT;
        end else if (issue) begin
          mem_re      = 1'b1;
          rd_idx_next = rd_idx + 1'b1;
          wr_idx_next = wr_idx + 1'b1;
        end else begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_FIN;
        end
      end
      // Each cycle moves one entry down by one place.
      S_SHIFT: begin
        if (rvalid) begin
          mem_we      = 1'b1;
          wr_idx_next = wr_idx + 1'b1;
          if (issue) begin
            mem_re      = 1'b1;
            rd_idx_next = rd_idx + 1'b1;
          end
          rvalid_next = issue;
        end else begin
          count_next      = count - 1'b1;
          res_status_next = ST_OK;
          state_next      = S_FIN;
        end
      end
      S_READ: begin
        res_id_next = ID_W'(rdata);
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rvalid <= rvalid_next;
    end
    rd_idx     <= rd_idx_next;
    wr_idx     <= wr_idx_next;
    is_deq     <= is_deq_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
  end

endmodule

`default_nettype wire

@@ rtl/trq_out.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Output register: holds one finished result until the sink takes it.
module trq_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire trq_pkg::result_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output trq_pkg::result_t       out_data
);
  import trq_pkg::*;

  result_t data;
  logic    valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/thread_run_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bounded first-in first-out queue of thread identifiers for a scheduler.
// Each input transaction carries one command: enqueue appends thread_id at
// the tail (status full when no slot is left), dequeue returns and removes
// the head (status empty when there is none), remove deletes the first
// entry from the head whose identifier matches and closes the gap (status
// empty or not found), and read returns the identifier at a position from
// the head (status not found past the tail). Every command produces exactly
// one output transaction, which also carries the entry count left after the
// command; result_id is zero unless a dequeue or read succeeds. Identifiers
// are cut to ID_BITS bits before they are stored or compared. The entries
// live in one synchronous memory with a registered read, and entry 0 is
// always the head. A dequeue or remove walks the memory once, one entry per
// cycle through its single read port, to find the match and move every
// later entry down by one place. One command is worked on at a time; a
// finished result sits in an output register, so the next command is
// taken while the sink still holds the previous result off.
module thread_run_queue #(
  parameter int DEPTH   = trq_pkg::DEPTH_DEFAULT,
  parameter int ID_BITS = trq_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from bit 0: cmd[1:0], thread_id[9:2], position[13:10], zero pad.
  input  wire logic [trq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // Fields from bit 0: status[1:0], result_id[9:2], entry_count[14:10], pad.
  output logic [trq_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
  import trq_pkg::*;

  req_t    req;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    res_ready;

  // Unpack the command fields; the two top bits are padding.
  assign req.cmd       = s_axis_tdata[1:0];
  assign req.thread_id = s_axis_tdata[9:2];
  assign req.position  = s_axis_tdata[13:10];

  trq_ctrl #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  trq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // The result struct already has status in the low bits; add the pad bit.
  assign m_axis_tdata = {1'b0, out_res};

endmodule

`default_nettype wire

@@ rtl/trq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "thread_run_queue_defines.svh"

module trq_checker #(
  parameter int DEPTH = trq_pkg::DEPTH_DEFAULT
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [trq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import trq_pkg::*;

  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_id;
  logic [COUNT_W-1:0]  out_count;
  logic                in_take;
  logic                out_wait;
  logic                out_fail;
  logic                out_full;
  logic                out_empty;

  assign out_status = m_axis_tdata[1:0];
  assign out_id     = m_axis_tdata[9:2];
  assign out_count  = m_axis_tdata[14:10];
  assign in_take    = s_axis_tvalid && s_axis_tready;
  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign out_fail   = m_axis_tvalid && (out_status != ST_OK);
  assign out_full   = m_axis_tvalid && (out_status == ST_FULL);
  assign out_empty  = m_axis_tvalid && (out_status == ST_EMPTY);

  `TRQ_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
  `TRQ_ASSERT_NEXT(a_one_cmd, clk, rst, in_take, !s_axis_tready)
  `TRQ_ASSERT_IMPL(a_id_zero_on_fail, clk, rst, out_fail, out_id == '0)
  `TRQ_ASSERT_IMPL(a_full_count, clk, rst, out_full, out_count == COUNT_W'(DEPTH))
  `TRQ_ASSERT_IMPL(a_empty_count, clk, rst, out_empty, out_count == '0)

endmodule

bind thread_run_queue trq_checker #(.DEPTH(DEPTH)) u_trq_checker (.*);

`default_nettype wire
